[rtl/core/u2u_pkg.sv]
// shared types, constants and byte classification for the utf-8 to utf-16 decoder
`timescale 1ns / 1ps
`default_nettype none

package u2u_pkg;

  // replacement character '?'
  localparam logic [15:0] REPL_UNIT    = 16'h003F;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [9:0]  SURR_MASK    = 10'h3FF;

  // lead byte masks and patterns
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } lead_cls_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        text_end;
  } out_item_t;

  // entry of the queue between front and back
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
    lead_cls_e  cls;
  } q_entry_t;

  function automatic lead_cls_e classify(input logic [7:0] b);
    lead_cls_e c;
    if (!b[7]) begin
      c = CLS_ASCII;
    end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      c = CLS_LEAD2;
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      c = CLS_LEAD3;
    end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_BAD;
    end
    return c;
  endfunction

  // continuation bytes a lead asks for
  function automatic logic [1:0] lead_need(input lead_cls_e c);
    logic [1:0] n;
    case (c)
      CLS_LEAD2: n = 2'd1;
      CLS_LEAD3: n = 2'd2;
      CLS_LEAD4: n = 2'd3;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

`default_nettype wire

[rtl/core/u2u_stream_if.sv]
// valid/ready stream interface with a typed payload
`timescale 1ns / 1ps
`default_nettype none

interface u2u_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/u2u_front.sv]
// front part: accepts bytes, classifies them and queues them for the back part
`timescale 1ns / 1ps
`default_nettype none

module u2u_front
  import u2u_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  u2u_stream_if.sink    in_i,
  u2u_stream_if.source  mid_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  q_entry_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  q_entry_t        wr_entry;

  assign in_i.ready    = (count_q != FullCnt);
  assign mid_o.valid   = (count_q != '0);
  assign mid_o.payload = mem_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = mid_o.valid && mid_o.ready;

  always_comb begin
    wr_entry.in_byte   = in_i.payload.in_byte;
    wr_entry.text_last = in_i.payload.text_last;
    wr_entry.cls       = classify(in_i.payload.in_byte);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count above depth");

  a_count_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count not decremented on pop");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

[rtl/core/u2u_back.sv]
// back part: sequence assembly, replay after bad continuation, surrogate split, output register
`timescale 1ns / 1ps
`default_nettype none

module u2u_back
  import u2u_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  u2u_stream_if.sink    mid_i,
  u2u_stream_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_LOW  = 4'b0100,
    ST_END  = 4'b1000
  } back_state_e;

  localparam logic [2:0] QMax = 3'd4;

  back_state_e state_q, state_d;

  // local work queue: the current byte plus replayed bytes
  logic [7:0]  qb_q [4];
  logic [7:0]  qb_d [4];
  lead_cls_e   qc_q [4];
  lead_cls_e   qc_d [4];
  logic [2:0]  qlen_q, qlen_d;
  logic        last_q, last_d;

  // buffered lead and continuation bytes
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  pcnt_q, pcnt_d;
  logic [1:0]  need_q, need_d;

  logic [15:0] lo_q, lo_d;
  logic [15:0] hold_q, hold_d;
  logic        hold_v_q, hold_v_d;
  out_item_t   out_q, out_d;
  logic        out_v_q, out_v_d;

  logic        can_push, go, produce, rel, push, mid_ready;
  logic [15:0] prod_unit;
  out_item_t   push_item;

  logic [7:0]  head_b, cont1, cont2, cont3;
  lead_cls_e   head_c;
  logic        seq_ok, big;
  logic [20:0] cp, vsub;
  logic [15:0] hi_unit, lo_unit;

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;
  assign mid_i.ready   = mid_ready;

  assign can_push = !out_v_q || out_o.ready;
  assign go       = !hold_v_q || can_push;

  // decode of a completed sequence
  always_comb begin
    head_b = qb_q[0];
    head_c = qc_q[0];
    cont1  = (pcnt_q == 2'd1) ? head_b : pend_q[1];
    cont2  = (pcnt_q == 2'd2) ? head_b : pend_q[2];
    cont3  = head_b;
    seq_ok = is_cont(cont1) && ((need_q < 2'd2) || is_cont(cont2)) &&
             ((need_q < 2'd3) || is_cont(cont3));
    case (need_q)
      2'd1:    cp = {10'd0, pend_q[0][4:0], cont1[5:0]};
      2'd2:    cp = {5'd0, pend_q[0][3:0], cont1[5:0], cont2[5:0]};
      2'd3:    cp = {pend_q[0][2:0], cont1[5:0], cont2[5:0], cont3[5:0]};
      default: cp = '0;
    endcase
    big     = (cp[20:16] != 5'd0);
    vsub    = cp - SUPP_BASE;
    hi_unit = SURR_HI_BASE + {5'd0, vsub[20:10]};
    lo_unit = SURR_LO_BASE | {6'd0, vsub[9:0] & SURR_MASK};
  end

  always_comb begin
    state_d   = state_q;
    qb_d      = qb_q;
    qc_d      = qc_q;
    qlen_d    = qlen_q;
    last_d    = last_q;
    pend_d    = pend_q;
    pcnt_d    = pcnt_q;
    need_d    = need_q;
    lo_d      = lo_q;
    produce   = 1'b0;
    prod_unit = REPL_UNIT;
    rel       = 1'b0;
    mid_ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        mid_ready = 1'b1;
        if (mid_i.valid) begin
          qb_d[0] = mid_i.payload.in_byte;
          qc_d[0] = mid_i.payload.cls;
          qlen_d  = 3'd1;
          last_d  = mid_i.payload.text_last;
          state_d = ST_RUN;
        end
      end

      ST_RUN: begin
        if (go) begin
          // plain pop
          qb_d[0] = qb_q[1];
          qb_d[1] = qb_q[2];
          qb_d[2] = qb_q[3];
          qc_d[0] = qc_q[1];
          qc_d[1] = qc_q[2];
          qc_d[2] = qc_q[3];
          qlen_d  = qlen_q - 3'd1;
          if (pcnt_q == 2'd0) begin
            case (head_c)
              CLS_ASCII: begin
                produce   = 1'b1;
                prod_unit = {8'd0, head_b};
              end
              CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                pend_d[0] = head_b;
                pcnt_d    = 2'd1;
                need_d    = lead_need(head_c);
              end
              default: begin
                produce   = 1'b1;
                prod_unit = REPL_UNIT;
              end
            endcase
          end else if (pcnt_q < need_q) begin
            pend_d[pcnt_q] = head_b;
            pcnt_d         = pcnt_q + 2'd1;
          end else begin
            pcnt_d = 2'd0;
            need_d = 2'd0;
            if (!seq_ok) begin
              // drop the lead, put its followers back in front of the queue
              produce   = 1'b1;
              prod_unit = REPL_UNIT;
              qlen_d    = qlen_q - 3'd1 + {1'b0, need_q};
              case (need_q)
                2'd1: begin
                  qb_d[0] = cont1;   qb_d[1] = qb_q[1];
                  qb_d[2] = qb_q[2]; qb_d[3] = qb_q[3];
                  qc_d[0] = classify(cont1); qc_d[1] = qc_q[1];
                  qc_d[2] = qc_q[2];         qc_d[3] = qc_q[3];
                end
                2'd2: begin
                  qb_d[0] = cont1;   qb_d[1] = cont2;
                  qb_d[2] = qb_q[1]; qb_d[3] = qb_q[2];
                  qc_d[0] = classify(cont1); qc_d[1] = classify(cont2);
                  qc_d[2] = qc_q[1];         qc_d[3] = qc_q[2];
                end
                default: begin
                  qb_d[0] = cont1;   qb_d[1] = cont2;
                  qb_d[2] = cont3;   qb_d[3] = qb_q[1];
                  qc_d[0] = classify(cont1); qc_d[1] = classify(cont2);
                  qc_d[2] = classify(cont3); qc_d[3] = qc_q[1];
                end
              endcase
            end else if (big) begin
              produce   = 1'b1;
              prod_unit = hi_unit;
              lo_d      = lo_unit;
            end else begin
              produce   = 1'b1;
              prod_unit = cp[15:0];
            end
          end
          if (pcnt_q != 2'd0 && pcnt_q == need_q && seq_ok && big) begin
            state_d = ST_LOW;
          end else if (qlen_d == 3'd0) begin
            state_d = ST_END;
          end
        end
      end

      ST_LOW: begin
        if (go) begin
          produce   = 1'b1;
          prod_unit = lo_q;
          state_d   = (qlen_q == 3'd0) ? ST_END : ST_RUN;
        end
      end

      ST_END: begin
        if (go) begin
          if (last_q && pcnt_q != 2'd0) begin
            // text ended inside a sequence
            produce   = 1'b1;
            prod_unit = REPL_UNIT;
            pcnt_d    = 2'd0;
            need_d    = 2'd0;
          end else begin
            rel       = hold_v_q;
            mid_ready = 1'b1;
            if (mid_i.valid) begin
              qb_d[0] = mid_i.payload.in_byte;
              qc_d[0] = mid_i.payload.cls;
              qlen_d  = 3'd1;
              last_d  = mid_i.payload.text_last;
              state_d = ST_RUN;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // one result is held back until the next one shows whether it closes the run
  always_comb begin
    hold_d    = hold_q;
    hold_v_d  = hold_v_q;
    push      = 1'b0;
    push_item = '{code_unit: hold_q, run_last: 1'b0, text_end: 1'b0};
    if (produce) begin
      push     = hold_v_q;
      hold_d   = prod_unit;
      hold_v_d = 1'b1;
    end
    if (rel) begin
      push      = 1'b1;
      push_item = '{code_unit: hold_q, run_last: 1'b1, text_end: last_q};
      hold_v_d  = 1'b0;
    end
    if (push) begin
      out_v_d = 1'b1;
      out_d   = push_item;
    end else begin
      out_v_d = out_v_q && !out_o.ready;
      out_d   = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      qlen_q   <= '0;
      last_q   <= 1'b0;
      pcnt_q   <= '0;
      need_q   <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      qlen_q   <= qlen_d;
      last_q   <= last_d;
      pcnt_q   <= pcnt_d;
      need_q   <= need_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qb_q   <= qb_d;
    qc_q   <= qc_d;
    pend_q <= pend_d;
    lo_q   <= lo_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

`ifndef ASSERT_OFF
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q != 2'd0) |-> (need_q != 2'd0 && pcnt_q <= need_q))
    else $error("buffered count beyond announced length");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q <= QMax)
    else $error("work queue overflow");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_v_q)
    else $error("held result left behind at idle");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> can_push)
    else $error("result pushed into a full output register");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.text_end) |-> out_q.run_last)
    else $error("text end without run end");
`endif

endmodule

`default_nettype wire

[rtl/core/utf8_to_utf16_stream_decoder.sv]
// top level of the utf-8 to utf-16 stream decoder
// usage:
//   in_i carries one utf-8 byte per transfer (in_byte) and text_last, which
//   marks the final byte of a text. out_o carries utf-16 code units with
//   run_last on the last unit caused by an input byte and text_end on the
//   final unit of a text. a bad lead byte, a bad continuation in a complete
//   sequence and a text ending inside a sequence each give '?' (0x003F);
//   after a bad continuation the lead is dropped and its followers re-decoded.
// timing:
//   a byte passes the back engine in a decode step and then a run-close
//   step of the single-step work loop there; a surrogate pair, each
//   replayed byte and an end-of-text '?' take steps of their own. the
//   first unit of a byte reaches the output register only once the next
//   unit or the run end is known, since one unit is held back until then;
//   bytes still in work ahead of it go first.
// reset: asynchronous, active low; empties the input queue, the sequence
//   buffer and the output register.
// stall: the input queue keeps taking bytes while the output waits, until it
//   fills; the back engine stops only when a unit has nowhere to go.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_stream_decoder
  import u2u_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  u2u_stream_if.sink    in_i,
  u2u_stream_if.source  out_o
);

  // classified bytes between front and back
  u2u_stream_if #(.payload_t(q_entry_t)) mid_if ();

  // front: accept, classify, queue
  u2u_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .mid_o  (mid_if)
  );

  // back: assemble sequences, replay, split surrogates, drive the output
  u2u_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mid_i  (mid_if),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
